/* sv/nnrs_pkg.sv */
// ----------------------------------------------------------------------------
// nnrs_pkg
// Shared types and constants of the nearest-neighbor RGB scaler.
// ----------------------------------------------------------------------------
package nnrs_pkg;

  localparam int unsigned PosW        = 9;
  localparam int unsigned LenW        = 10;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned PixBytes    = 3;
  localparam int unsigned PixW        = PixBytes * ChanW;
  localparam int unsigned QuotW       = LenW;
  localparam int unsigned ProdW       = PosW + LenW;
  localparam int unsigned CmpW        = 14;
  localparam int unsigned MapLatency  = QuotW + 2;
  localparam int unsigned FifoDepth   = 32;
  localparam int unsigned CntW        = $clog2(FifoDepth + 1);

  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;
  localparam int unsigned CfgResetDim    = 512;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic             cmd;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             out_of_range;
  } out_item_t;

endpackage

/* sv/nnrs_coord_map.sv */
// ----------------------------------------------------------------------------
// nnrs_coord_map
// Maps a destination coordinate to a source coordinate: pos*src/dst with a
// pipelined restoring divider, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module nnrs_coord_map import nnrs_pkg::*; #(
  parameter int unsigned LIMIT = MAX_WIDTH_DEF,
  localparam int unsigned CW = (LIMIT > 1) ? $clog2(LIMIT) : 1
) (
  input  logic            clk,
  input  logic [PosW-1:0] pos,
  input  logic [LenW-1:0] src_len,
  input  logic [LenW-1:0] dst_len,
  output logic [CW-1:0]   coord
);

  logic [ProdW-1:0] prod;
  logic [LenW-1:0]  rem_q [QuotW];
  logic [QuotW-1:0] low_q [QuotW];
  logic [QuotW-1:0] quo_q [QuotW];
  logic [CmpW-1:0]  q_ext;
  logic [CmpW-1:0]  sat_ext;

  always_ff @(posedge clk) begin
    prod <= ProdW'(pos) * ProdW'(src_len);
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    logic [LenW-1:0]  rem_in;
    logic [QuotW-1:0] low_in;
    logic [QuotW-1:0] quo_in;
    logic [LenW:0]    trial;

    if (k == 0) begin : g_first
      assign rem_in = LenW'(prod[ProdW-1:QuotW]);
      assign low_in = prod[QuotW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, low_in[QuotW-1]};

    always_ff @(posedge clk) begin
      low_q[k] <= low_in << 1;
      if (trial >= {1'b0, dst_len}) begin
        rem_q[k] <= LenW'(trial - {1'b0, dst_len});
        quo_q[k] <= {quo_in[QuotW-2:0], 1'b1};
      end else begin
        rem_q[k] <= trial[LenW-1:0];
        quo_q[k] <= {quo_in[QuotW-2:0], 1'b0};
      end
    end
  end

  assign q_ext   = CmpW'(quo_q[QuotW-1]);
  assign sat_ext = (q_ext >= CmpW'(LIMIT)) ? CmpW'(LIMIT - 1) : q_ext;

  always_ff @(posedge clk) begin
    coord <= sat_ext[CW-1:0];
  end

endmodule

/* sv/nnrs_frame_mem.sv */
// ----------------------------------------------------------------------------
// nnrs_frame_mem
// Single-port frame store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module nnrs_frame_mem import nnrs_pkg::*; #(
  parameter int unsigned AW = 18
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   addr,
  input  logic [PixW-1:0] wdata,
  output logic [PixW-1:0] rdata
);

  logic [PixW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/nnrs_out_fifo.sv */
// ----------------------------------------------------------------------------
// nnrs_out_fifo
// Result queue; the top level reserves a slot before a read enters.
// ----------------------------------------------------------------------------
module nnrs_out_fifo import nnrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_item,
  input  logic      pop,
  output logic      valid,
  output out_item_t item
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  out_item_t       slots [FifoDepth];
  logic [PtrW:0]   wr_ptr;
  logic [PtrW:0]   rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[PtrW-1:0]] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  assign valid = (wr_ptr != rd_ptr);
  assign item  = slots[rd_ptr[PtrW-1:0]];

endmodule

/* sv/nearest_neighbor_rgb_scaler.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_rgb_scaler
// Nearest-neighbor RGB scaler with a frame store of source pixels.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_ready is high. A write stores a
// pixel; a read returns the source pixel at (x*src_width/dst_width,
// y*src_height/dst_height). Every transaction goes through the same pipeline:
// multiply, a 10-stage divider (one quotient bit per stage), saturation, then
// the frame store port, so a read sees exactly the writes accepted before it.
// A read result is pushed into the output queue after the frame store read
// and can leave at the next edge. in_ready drops only when 32 read results are
// queued or in flight. The store is not cleared.
// ----------------------------------------------------------------------------
module nearest_neighbor_rgb_scaler import nnrs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  cfg_index_t      cfg_index,
  input  logic [LenW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_item
);

  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW = XW + YW;

  typedef struct packed {
    logic            cmd;
    logic            oor;
    logic            wr_ok;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [PixW-1:0] pix;
  } meta_t;

  logic [LenW-1:0] src_width, src_height, dst_width, dst_height;
  logic [CntW-1:0] cnt;
  logic            in_fire, out_fire, rd_acc;
  meta_t           meta_in, m_tail;
  meta_t           meta_q [MapLatency];
  logic [MapLatency-1:0] vld_q;
  logic [XW-1:0]   sx;
  logic [YW-1:0]   sy;
  logic [CmpW-1:0] wx_ext, wy_ext;
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [PixW-1:0] mem_rdata;
  logic            rd_vld, rd_oor;
  out_item_t       push_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= LenW'(CfgResetDim);
      src_height <= LenW'(CfgResetDim);
      dst_width  <= LenW'(CfgResetDim);
      dst_height <= LenW'(CfgResetDim);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data;
        CFG_SRC_HEIGHT: src_height <= cfg_data;
        CFG_DST_WIDTH:  dst_width  <= cfg_data;
        CFG_DST_HEIGHT: dst_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (cnt < CntW'(FifoDepth));
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign rd_acc   = in_fire && (in_item.cmd == CMD_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CntW'(rd_acc) - CntW'(out_fire);
    end
  end

  assign meta_in.cmd   = in_item.cmd;
  assign meta_in.oor   = ({1'b0, in_item.pos_x} >= dst_width) ||
                         ({1'b0, in_item.pos_y} >= dst_height);
  assign meta_in.wr_ok = (CmpW'(in_item.pos_x) < CmpW'(MAX_WIDTH)) &&
                         (CmpW'(in_item.pos_y) < CmpW'(MAX_HEIGHT));
  assign meta_in.pos_x = in_item.pos_x;
  assign meta_in.pos_y = in_item.pos_y;
  assign meta_in.pix   = {in_item.red_in, in_item.green_in, in_item.blue_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[MapLatency-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    meta_q[0] <= meta_in;
    for (int k = 1; k < MapLatency; k++) begin
      meta_q[k] <= meta_q[k-1];
    end
  end

  nnrs_coord_map #(.LIMIT(MAX_WIDTH)) u_map_x (
    .clk     (clk),
    .pos     (in_item.pos_x),
    .src_len (src_width),
    .dst_len (dst_width),
    .coord   (sx)
  );

  nnrs_coord_map #(.LIMIT(MAX_HEIGHT)) u_map_y (
    .clk     (clk),
    .pos     (in_item.pos_y),
    .src_len (src_height),
    .dst_len (dst_height),
    .coord   (sy)
  );

  assign m_tail   = meta_q[MapLatency-1];
  assign wx_ext   = CmpW'(m_tail.pos_x);
  assign wy_ext   = CmpW'(m_tail.pos_y);
  assign mem_we   = vld_q[MapLatency-1] && (m_tail.cmd == CMD_WRITE) && m_tail.wr_ok;
  assign mem_addr = (m_tail.cmd == CMD_WRITE) ? {wy_ext[YW-1:0], wx_ext[XW-1:0]}
                                              : {sy, sx};

  nnrs_frame_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (m_tail.pix),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld_q[MapLatency-1] && (m_tail.cmd == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    rd_oor <= m_tail.oor;
  end

  always_comb begin
    if (rd_oor) begin
      push_item = '{red_out: '0, green_out: '0, blue_out: '0, out_of_range: 1'b1};
    end else begin
      push_item = '{red_out:   mem_rdata[PixW-1 -: ChanW],
                    green_out: mem_rdata[2*ChanW-1 -: ChanW],
                    blue_out:  mem_rdata[ChanW-1:0],
                    out_of_range: 1'b0};
    end
  end

  nnrs_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_vld),
    .push_item (push_item),
    .pop       (out_fire),
    .valid     (out_valid),
    .item      (out_item)
  );

endmodule

/* sv/nnrs_checker.sv */
// ----------------------------------------------------------------------------
// nnrs_checker
// Port-level checks for the scaler, bound to the top level.
// ----------------------------------------------------------------------------
module nnrs_checker import nnrs_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input out_item_t       out_item
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.out_of_range |->
      out_item.red_out == '0 && out_item.green_out == '0 && out_item.blue_out == '0)
    else $error("out of range result carries pixel data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind nearest_neighbor_rgb_scaler nnrs_checker u_nnrs_checker (.*);

/* test/tb_nearest_neighbor_rgb_scaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_rgb_scaler
// Self-checking bench for the nearest-neighbor RGB scaler: it keeps its own
// copy of the frame store and geometry, predicts every read result and
// checks each output transaction in order, under random idle and stall.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_rgb_scaler;
  import nnrs_pkg::*;

  localparam int unsigned StoreW      = MAX_WIDTH_DEF;
  localparam int unsigned StoreH      = MAX_HEIGHT_DEF;
  localparam int unsigned DrainCycles = MapLatency + 12;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned PhaseItems  = 30;
  localparam int unsigned CycleLimit  = 200000;

  logic            clk;
  logic            rst = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  cfg_index_t      cfg_index = CFG_SRC_WIDTH;
  logic [LenW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_item = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_item;

  nearest_neighbor_rgb_scaler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // mirror of the frame store and of the geometry registers
  bit [PixW-1:0] image_mirror [StoreW*StoreH];
  bit            pixel_written [StoreW*StoreH];
  int unsigned   src_w = CfgResetDim;
  int unsigned   src_h = CfgResetDim;
  int unsigned   dst_w = CfgResetDim;
  int unsigned   dst_h = CfgResetDim;

  out_item_t expected_pixels [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        out_hold = 1'b0;

  int unsigned fail_count     = 0;
  int unsigned writes_sent    = 0;
  int unsigned reads_sent     = 0;
  int unsigned reads_outside  = 0;
  int unsigned results_seen   = 0;
  int unsigned geometries     = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_pixels.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_failure(input string msg);
    if (fail_count < 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        report_failure($sformatf("unexpected result r=%h g=%h b=%h oor=%b",
                                 out_item.red_out, out_item.green_out,
                                 out_item.blue_out, out_item.out_of_range));
      end else begin
        want = expected_pixels.pop_front();
        if (want.red_out !== out_item.red_out || want.green_out !== out_item.green_out ||
            want.blue_out !== out_item.blue_out ||
            want.out_of_range !== out_item.out_of_range) begin
          report_failure($sformatf("expected r=%h g=%h b=%h oor=%b, got r=%h g=%h b=%h oor=%b",
                                   want.red_out, want.green_out, want.blue_out,
                                   want.out_of_range, out_item.red_out, out_item.green_out,
                                   out_item.blue_out, out_item.out_of_range));
        end
      end
    end
  end

  function automatic int unsigned map_to_source(input int unsigned pos, input int unsigned src_len,
                                                input int unsigned dst_len,
                                                input int unsigned limit);
    int unsigned s;
    s = (pos * src_len) / dst_len;
    if (s >= limit) s = limit - 1;
    return s;
  endfunction

  function automatic bit in_output(input int unsigned x, input int unsigned y);
    return (x < dst_w) && (y < dst_h);
  endfunction

  function automatic int unsigned source_index(input int unsigned x, input int unsigned y);
    return map_to_source(y, src_h, dst_h, StoreH) * StoreW +
           map_to_source(x, src_w, dst_w, StoreW);
  endfunction

  // update the mirror on a write, queue the scaled pixel on a read
  function automatic void accept_transaction(input in_item_t it);
    out_item_t   res;
    int unsigned idx;
    if (it.cmd == CMD_WRITE) begin
      idx = it.pos_y * StoreW + it.pos_x;
      image_mirror[idx] = {it.red_in, it.green_in, it.blue_in};
      pixel_written[idx] = 1'b1;
      writes_sent++;
    end else begin
      res = '0;
      reads_sent++;
      if (!in_output(it.pos_x, it.pos_y)) begin
        res.out_of_range = 1'b1;
        reads_outside++;
      end else begin
        {res.red_out, res.green_out, res.blue_out} =
          image_mirror[source_index(it.pos_x, it.pos_y)];
      end
      expected_pixels.push_back(res);
    end
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accept_transaction(it);
  endtask

  task automatic put_pixel(input int unsigned x, input int unsigned y,
                           input logic [PixW-1:0] rgb);
    in_item_t it;
    it.cmd = CMD_WRITE;
    it.pos_x = PosW'(x);
    it.pos_y = PosW'(y);
    {it.red_in, it.green_in, it.blue_in} = rgb;
    send_item(it);
  endtask

  // a read of a source pixel that was never stored is preceded by a write to it
  task automatic read_pixel(input int unsigned x, input int unsigned y);
    in_item_t    it;
    int unsigned idx;
    if (in_output(x, y)) begin
      idx = source_index(x, y);
      if (!pixel_written[idx]) put_pixel(idx % StoreW, idx / StoreW, PixW'($urandom()));
    end
    it = '0;
    it.cmd = CMD_READ;
    it.pos_x = PosW'(x);
    it.pos_y = PosW'(y);
    it.red_in = ChanW'($urandom_range(255));
    it.green_in = ChanW'($urandom_range(255));
    it.blue_in = ChanW'($urandom_range(255));
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LenW'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH:  src_w = val;
      CFG_SRC_HEIGHT: src_h = val;
      CFG_DST_WIDTH:  dst_w = val;
      CFG_DST_HEIGHT: dst_h = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                              input int unsigned dw, input int unsigned dh);
    write_register(CFG_SRC_WIDTH, sw);
    write_register(CFG_SRC_HEIGHT, sh);
    write_register(CFG_DST_WIDTH, dw);
    write_register(CFG_DST_HEIGHT, dh);
    cfg_valid <= 1'b0;
    geometries++;
  endtask

  function automatic int unsigned pick_length();
    case ($urandom_range(9))
      0: return 1;
      1: return 512;
      2: return 511;
      3: return 2;
      default: return $urandom_range(512, 1);
    endcase
  endfunction

  task automatic test_identity_corners();
    set_geometry(512, 512, 512, 512);
    put_pixel(0, 0, 24'h000000);
    put_pixel(511, 0, 24'hFF0000);
    put_pixel(0, 511, 24'h00FF00);
    put_pixel(511, 511, 24'h0000FF);
    put_pixel(255, 256, 24'hA55AC3);
    read_pixel(0, 0);
    read_pixel(511, 0);
    read_pixel(0, 511);
    read_pixel(511, 511);
    read_pixel(255, 256);
    put_pixel(255, 256, 24'hFFFFFF);
    read_pixel(255, 256);
    wait_idle();
  endtask

  task automatic test_output_bounds();
    set_geometry(512, 512, 300, 200);
    read_pixel(299, 199);
    read_pixel(300, 0);
    read_pixel(0, 200);
    read_pixel(511, 511);
    read_pixel(0, 0);
    wait_idle();
  endtask

  task automatic test_scale_extremes();
    set_geometry(1, 1, 512, 512);
    read_pixel(511, 511);
    read_pixel(17, 300);
    wait_idle();
    set_geometry(512, 512, 1, 1);
    read_pixel(0, 0);
    read_pixel(1, 0);
    read_pixel(0, 1);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int p = 0; p < 3; p++) begin
      set_geometry(pick_length(), pick_length(), pick_length(), pick_length());
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(99) < 35) begin
          put_pixel($urandom_range(511), $urandom_range(511), PixW'($urandom()));
        end else if ($urandom_range(99) < 80) begin
          read_pixel($urandom_range(dst_w - 1), $urandom_range(dst_h - 1));
        end else begin
          read_pixel($urandom_range(511), $urandom_range(511));
        end
      end
      wait_idle();
    end
  endtask

  // output held off while reads keep coming, so the input must stall
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_geometry(pick_length(), pick_length(), 512, 512);
    fork
      begin
        out_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 48; i++) begin
      read_pixel($urandom_range(511), $urandom_range(511));
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct  = 28;
    recv_stall_pct = 52;
    test_identity_corners();
    test_output_bounds();
    test_scale_extremes();
    test_random_traffic(28, 52);
    test_random_traffic(52, 28);
    test_random_traffic(0, 0);
    test_backpressure();
    $display("Sent %0d pixel writes and %0d reads (%0d outside the output) over %0d geometries",
             writes_sent, reads_sent, reads_outside, geometries);
    $display("Checked %0d results, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* nearest_neighbor_rgb_scaler.f */
sv/nnrs_pkg.sv
sv/nnrs_coord_map.sv
sv/nnrs_frame_mem.sv
sv/nnrs_out_fifo.sv
sv/nearest_neighbor_rgb_scaler.sv
sv/nnrs_checker.sv
test/tb_nearest_neighbor_rgb_scaler.sv
